// ----- sv/ohsl_pkg.sv -----
// Shared types, codes and defaults for the open-addressed hash set with list.
package ohsl_pkg;

    localparam int TABLE_SIZE_DEF    = 256;
    localparam int LIST_CAP_DEF      = 128;
    localparam int ENTITY_BITS_DEF   = 32;
    localparam int COLLIDER_BITS_DEF = 8;

    localparam logic [31:0] HASH_MULT_RESET = 32'd2654435769;

    localparam logic [2:0] ACT_INSERT  = 3'd0;
    localparam logic [2:0] ACT_LOOKUP  = 3'd1;
    localparam logic [2:0] ACT_REMOVE  = 3'd2;
    localparam logic [2:0] ACT_REM_POS = 3'd3;
    localparam logic [2:0] ACT_READ    = 3'd4;
    localparam logic [2:0] ACT_MARK    = 3'd5;

    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_PRESENT  = 3'd1;
    localparam logic [2:0] STS_NOTFOUND = 3'd2;
    localparam logic [2:0] STS_FULL     = 3'd3;
    localparam logic [2:0] STS_RANGE    = 3'd4;

    localparam logic [1:0] SLOT_FREE = 2'd0;
    localparam logic [1:0] SLOT_USED = 2'd1;
    localparam logic [1:0] SLOT_TOMB = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_HOME,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_INS_WR,
        ST_POS_CHK,
        ST_POS_RD,
        ST_POS_ENT,
        ST_POS_USE,
        ST_REM_RD,
        ST_REM_WR,
        ST_RESULT,
        ST_CLEAR
    } fsm_state_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_ENTRY,
        RES_NEW
    } res_sel_t;

    typedef struct packed {
        logic       ld_req;
        logic       hash_mul;
        logic       probe_init;
        logic       ent_rd;
        logic       ent_rd_slot;
        logic       probe_chk;
        logic       probe_next;
        logic       probe_hit;
        logic       ins;
        logic       list_rd_p;
        logic       ld_slot_list;
        logic       set_mark;
        logic       rem_start;
        logic       rem_move;
        logic       out_ld;
        logic [2:0] res_status;
        logic       res_found;
        res_sel_t   res_sel;
        logic       clr;
    } dp_cmd_t;

    typedef struct packed {
        logic hit;
        logic miss_end;
        logic full;
        logic pos_ok;
        logic p_ok;
        logic clr_done;
    } dp_sts_t;

endpackage

// ----- sv/ohsl_ctrl.sv -----
// Controller state machine: sequences probes, inserts, removals and result hand-off.
module ohsl_ctrl import ohsl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_action,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_sts_t    sts,
    output dp_cmd_t    cmd
);

    fsm_state_t state_reg, state_next;
    logic [2:0] action_reg;
    logic [2:0] res_status_reg, res_status_next;
    logic       res_found_reg, res_found_next;
    res_sel_t   res_sel_reg, res_sel_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            m_valid_reg    <= 1'b0;
            res_status_reg <= STS_OK;
            res_found_reg  <= 1'b0;
            res_sel_reg    <= RES_NONE;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            res_status_reg <= res_status_next;
            res_found_reg  <= res_found_next;
            res_sel_reg    <= res_sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            action_reg <= s_action;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_action)
                        ACT_INSERT, ACT_LOOKUP, ACT_REMOVE: state_next = ST_HASH;
                        ACT_REM_POS, ACT_READ, ACT_MARK:   state_next = ST_POS_CHK;
                        default:                           state_next = ST_RESULT;
                    endcase
                end
            end
            ST_HASH:     state_next = ST_HOME;
            ST_HOME:     state_next = ST_PROBE_RD;
            ST_PROBE_RD: state_next = ST_PROBE_CHK;
            ST_PROBE_CHK: begin
                if (sts.hit) begin
                    if (action_reg == ACT_REMOVE && sts.pos_ok) begin
                        state_next = ST_REM_RD;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end else if (sts.miss_end) begin
                    if (action_reg == ACT_INSERT && !sts.full) begin
                        state_next = ST_INS_WR;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end else begin
                    state_next = ST_PROBE_RD;
                end
            end
            ST_INS_WR:  state_next = ST_RESULT;
            ST_POS_CHK: state_next = sts.p_ok ? ST_POS_RD : ST_RESULT;
            ST_POS_RD:  state_next = ST_POS_ENT;
            ST_POS_ENT: state_next = ST_POS_USE;
            ST_POS_USE: state_next = (action_reg == ACT_REM_POS) ? ST_REM_RD : ST_RESULT;
            ST_REM_RD:  state_next = ST_REM_WR;
            ST_REM_WR:  state_next = ST_RESULT;
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.res_sel     = res_sel_reg;
        cmd.res_status  = res_status_reg;
        cmd.res_found   = res_found_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_sel_next    = res_sel_reg;
        case (state_reg)
            ST_CLEAR: cmd.clr = 1'b1;
            ST_IDLE: begin
                cmd.ld_req = s_valid;
                if (s_valid) begin
                    res_status_next = STS_NOTFOUND;
                    res_found_next  = 1'b0;
                    res_sel_next    = RES_NONE;
                end
            end
            ST_HASH:     cmd.hash_mul   = 1'b1;
            ST_HOME:     cmd.probe_init = 1'b1;
            ST_PROBE_RD: cmd.ent_rd     = 1'b1;
            ST_PROBE_CHK: begin
                cmd.probe_chk = 1'b1;
                if (sts.hit) begin
                    cmd.probe_hit = 1'b1;
                    case (action_reg)
                        ACT_INSERT: begin
                            res_status_next = STS_PRESENT;
                            res_found_next  = 1'b1;
                            res_sel_next    = RES_ENTRY;
                        end
                        ACT_LOOKUP: begin
                            res_status_next = STS_OK;
                            res_found_next  = 1'b1;
                            res_sel_next    = RES_ENTRY;
                        end
                        default: begin
                            res_status_next = sts.pos_ok ? STS_OK : STS_NOTFOUND;
                            res_found_next  = sts.pos_ok;
                            res_sel_next    = sts.pos_ok ? RES_ENTRY : RES_NONE;
                        end
                    endcase
                end else if (sts.miss_end) begin
                    if (action_reg == ACT_INSERT) begin
                        res_status_next = sts.full ? STS_FULL : STS_OK;
                        res_found_next  = 1'b0;
                        res_sel_next    = sts.full ? RES_NONE : RES_NEW;
                    end else begin
                        res_status_next = STS_NOTFOUND;
                        res_found_next  = 1'b0;
                        res_sel_next    = RES_NONE;
                    end
                end else begin
                    cmd.probe_next = 1'b1;
                end
            end
            ST_INS_WR: cmd.ins = 1'b1;
            ST_POS_CHK: begin
                cmd.list_rd_p = 1'b1;
                if (!sts.p_ok) begin
                    res_status_next = STS_RANGE;
                    res_found_next  = 1'b0;
                    res_sel_next    = RES_NONE;
                end
            end
            ST_POS_RD: cmd.ld_slot_list = 1'b1;
            ST_POS_ENT: begin
                cmd.ent_rd      = 1'b1;
                cmd.ent_rd_slot = 1'b1;
            end
            ST_POS_USE: begin
                cmd.set_mark    = (action_reg == ACT_MARK);
                res_status_next = STS_OK;
                res_found_next  = 1'b1;
                res_sel_next    = RES_ENTRY;
            end
            ST_REM_RD:  cmd.rem_start = 1'b1;
            ST_REM_WR:  cmd.rem_move  = 1'b1;
            ST_RESULT:  cmd.out_ld    = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_ld) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ----- sv/ohsl_dp.sv -----
// Datapath: hash unit, slot status, key/position/list memories and result registers.
module ohsl_dp import ohsl_pkg::*; #(
    parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
    parameter int LIST_CAP      = LIST_CAP_DEF,
    parameter int ENTITY_BITS   = ENTITY_BITS_DEF,
    parameter int COLLIDER_BITS = COLLIDER_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic [31:0] s_entity_id,
    input  logic [7:0]  s_collider_index,
    input  logic [6:0]  s_position,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    output logic [2:0]  m_status,
    output logic        m_found,
    output logic [7:0]  m_slot,
    output logic [6:0]  m_list_position,
    output logic [31:0] m_entity_out,
    output logic [7:0]  m_collider_out,
    output logic        m_marked,
    output logic [7:0]  m_count
);

    localparam int SLOT_W = $clog2(TABLE_SIZE);
    localparam int POS_W  = $clog2(LIST_CAP);
    localparam int CNT_W  = $clog2(LIST_CAP + 1);
    localparam int LIMIT  = (TABLE_SIZE / 2 < LIST_CAP) ? TABLE_SIZE / 2 : LIST_CAP;

    logic [31:0]              mult_reg;
    logic [ENTITY_BITS-1:0]   ent_in_reg;
    logic [COLLIDER_BITS-1:0] col_in_reg;
    logic [6:0]               p_in_reg;
    logic [31:0]              prod_reg;
    logic [SLOT_W-1:0]        probe_reg;
    logic [SLOT_W-1:0]        pcnt_reg;
    logic                     avail_vld_reg;
    logic [SLOT_W-1:0]        avail_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [SLOT_W-1:0]        clr_reg;

    logic [1:0]               st_mem   [TABLE_SIZE];
    logic                     mark_mem [TABLE_SIZE];
    logic [ENTITY_BITS-1:0]   ent_mem  [TABLE_SIZE];
    logic [COLLIDER_BITS-1:0] col_mem  [TABLE_SIZE];
    logic [POS_W-1:0]         pos_mem  [TABLE_SIZE];
    logic [SLOT_W-1:0]        list_mem [LIST_CAP];

    logic [1:0]               rd_st_reg;
    logic                     rd_mark_reg;
    logic [ENTITY_BITS-1:0]   rd_ent_reg;
    logic [COLLIDER_BITS-1:0] rd_col_reg;
    logic [POS_W-1:0]         rd_pos_reg;
    logic [SLOT_W-1:0]        list_rd_reg;

    logic [2:0]  out_status_reg;
    logic        out_found_reg;
    logic [7:0]  out_slot_reg;
    logic [6:0]  out_pos_reg;
    logic [31:0] out_ent_reg;
    logic [7:0]  out_col_reg;
    logic        out_mark_reg;
    logic [7:0]  out_count_reg;

    logic [31:0]       key32;
    logic [SLOT_W-1:0] ent_addr;
    logic              key_match;
    logic              avail_take;
    logic              st_we;
    logic [SLOT_W-1:0] st_waddr;
    logic [1:0]        st_wdata;
    logic              mark_we;
    logic [SLOT_W-1:0] mark_waddr;
    logic [SLOT_W-1:0] pos_waddr;
    logic [POS_W-1:0]  pos_wdata;
    logic [POS_W-1:0]  list_waddr;
    logic [SLOT_W-1:0] list_wdata;
    logic [POS_W-1:0]  list_raddr;

    assign key32      = 32'(ent_in_reg) + 32'(col_in_reg);
    assign ent_addr   = cmd.ent_rd_slot ? slot_reg : probe_reg;
    assign key_match  = (rd_ent_reg == ent_in_reg) && (rd_col_reg == col_in_reg);
    assign avail_take = cmd.probe_chk && !avail_vld_reg && rd_st_reg != SLOT_USED;
    assign st_we      = cmd.clr || cmd.ins || cmd.rem_start;
    assign st_waddr   = cmd.clr ? clr_reg : (cmd.ins ? avail_reg : slot_reg);
    assign st_wdata   = cmd.clr ? SLOT_FREE : (cmd.ins ? SLOT_USED : SLOT_TOMB);
    assign mark_we    = cmd.ins || cmd.set_mark;
    assign mark_waddr = cmd.ins ? avail_reg : slot_reg;
    assign pos_waddr  = cmd.ins ? avail_reg : list_rd_reg;
    assign pos_wdata  = cmd.ins ? POS_W'(count_reg) : pos_reg;
    assign list_waddr = cmd.ins ? POS_W'(count_reg) : pos_reg;
    assign list_wdata = cmd.ins ? avail_reg : list_rd_reg;
    assign list_raddr = cmd.list_rd_p ? POS_W'(p_in_reg) : POS_W'(count_reg - CNT_W'(1));

    assign sts.hit      = (rd_st_reg == SLOT_USED) && key_match;
    assign sts.miss_end = (rd_st_reg == SLOT_FREE) || (pcnt_reg == SLOT_W'(TABLE_SIZE - 1));
    assign sts.full     = count_reg >= CNT_W'(LIMIT);
    assign sts.pos_ok   = CNT_W'(rd_pos_reg) < count_reg;
    assign sts.p_ok     = 32'(p_in_reg) < 32'(count_reg);
    assign sts.clr_done = (clr_reg == SLOT_W'(TABLE_SIZE - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg      <= HASH_MULT_RESET;
            count_reg     <= '0;
            avail_vld_reg <= 1'b0;
            clr_reg       <= '0;
        end else begin
            if (cfg_we) begin
                mult_reg <= cfg_wdata;
            end
            if (cmd.clr) begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
            if (cmd.probe_init) begin
                avail_vld_reg <= 1'b0;
            end else if (avail_take) begin
                avail_vld_reg <= 1'b1;
            end
            if (cmd.ins) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.rem_start) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_req) begin
            ent_in_reg <= ENTITY_BITS'(s_entity_id);
            col_in_reg <= COLLIDER_BITS'(s_collider_index);
            p_in_reg   <= s_position;
        end
        if (cmd.hash_mul) begin
            prod_reg <= key32 * mult_reg;
        end
        if (cmd.probe_init) begin
            probe_reg <= prod_reg[31 -: SLOT_W];
            pcnt_reg  <= '0;
        end else if (cmd.probe_next) begin
            probe_reg <= probe_reg + SLOT_W'(1);
            pcnt_reg  <= pcnt_reg + SLOT_W'(1);
        end
        if (avail_take) begin
            avail_reg <= probe_reg;
        end
        if (cmd.probe_hit) begin
            slot_reg <= probe_reg;
            pos_reg  <= rd_pos_reg;
        end else if (cmd.ins) begin
            slot_reg <= avail_reg;
            pos_reg  <= POS_W'(count_reg);
        end else if (cmd.ld_slot_list) begin
            slot_reg <= list_rd_reg;
            pos_reg  <= POS_W'(p_in_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (cmd.ent_rd) begin
            rd_st_reg <= st_mem[ent_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= cmd.set_mark;
        end
        if (cmd.ent_rd) begin
            rd_mark_reg <= mark_mem[ent_addr];
        end else if (cmd.set_mark) begin
            rd_mark_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins) begin
            ent_mem[avail_reg] <= ent_in_reg;
            col_mem[avail_reg] <= col_in_reg;
        end
        if (cmd.ent_rd) begin
            rd_ent_reg <= ent_mem[ent_addr];
            rd_col_reg <= col_mem[ent_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins || cmd.rem_move) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (cmd.ent_rd) begin
            rd_pos_reg <= pos_mem[ent_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins || cmd.rem_move) begin
            list_mem[list_waddr] <= list_wdata;
        end
        if (cmd.list_rd_p || cmd.rem_start) begin
            list_rd_reg <= list_mem[list_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            out_status_reg <= cmd.res_status;
            out_found_reg  <= cmd.res_found;
            out_count_reg  <= 8'(count_reg);
            case (cmd.res_sel)
                RES_ENTRY: begin
                    out_slot_reg <= 8'(slot_reg);
                    out_pos_reg  <= 7'(pos_reg);
                    out_ent_reg  <= 32'(rd_ent_reg);
                    out_col_reg  <= 8'(rd_col_reg);
                    out_mark_reg <= rd_mark_reg;
                end
                RES_NEW: begin
                    out_slot_reg <= 8'(slot_reg);
                    out_pos_reg  <= 7'(pos_reg);
                    out_ent_reg  <= 32'(ent_in_reg);
                    out_col_reg  <= 8'(col_in_reg);
                    out_mark_reg <= 1'b0;
                end
                default: begin
                    out_slot_reg <= '0;
                    out_pos_reg  <= '0;
                    out_ent_reg  <= '0;
                    out_col_reg  <= '0;
                    out_mark_reg <= 1'b0;
                end
            endcase
        end
    end

    assign m_status        = out_status_reg;
    assign m_found         = out_found_reg;
    assign m_slot          = out_slot_reg;
    assign m_list_position = out_pos_reg;
    assign m_entity_out    = out_ent_reg;
    assign m_collider_out  = out_col_reg;
    assign m_marked        = out_mark_reg;
    assign m_count         = out_count_reg;

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(LIMIT))
        else $error("entry count beyond limit");

    a_ins_target: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |-> avail_vld_reg)
        else $error("insert with no free slot found");

    a_rem_target: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rem_start |-> rd_st_reg == SLOT_USED)
        else $error("removal of slot not in use");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not advance count");

endmodule

// ----- sv/open_addressed_hash_set_with_list_core.sv -----
// Top level of the open-addressed hash set with dense entry list.
// Keeps (entity, collider) keys in a linear-probed table with tombstones and a dense list of
// occupied slots. One request is handled at a time. Each request is taken when idle and its
// result is loaded into the output register in its final cycle; the input side accepts again
// once that result is registered, even while it still waits on m_ready. Key actions (insert,
// lookup, remove by key) hash the key and probe from its home slot; each probe is a
// registered read of the slot memories followed by a compare; an insert adds a write step,
// a removal two list-update steps. Positional actions check the position, then read the list
// and the key; a removal adds both update steps. A position out of range answers after the
// check, an unknown action at once. The result step holds while an earlier one still waits
// on m_ready. Inserts are refused once the count reaches half the table or the list
// capacity. A clearing pass after reset marks every slot free before any request is taken.
module open_addressed_hash_set_with_list_core import ohsl_pkg::*; #(
    parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
    parameter int LIST_CAP      = LIST_CAP_DEF,
    parameter int ENTITY_BITS   = ENTITY_BITS_DEF,
    parameter int COLLIDER_BITS = COLLIDER_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [31:0] s_entity_id,
    input  logic [7:0]  s_collider_index,
    input  logic [6:0]  s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_found,
    output logic [7:0]  m_slot,
    output logic [6:0]  m_list_position,
    output logic [31:0] m_entity_out,
    output logic [7:0]  m_collider_out,
    output logic        m_marked,
    output logic [7:0]  m_count
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    ohsl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ohsl_dp #(
        .TABLE_SIZE    (TABLE_SIZE),
        .LIST_CAP      (LIST_CAP),
        .ENTITY_BITS   (ENTITY_BITS),
        .COLLIDER_BITS (COLLIDER_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_entity_id      (s_entity_id),
        .s_collider_index (s_collider_index),
        .s_position       (s_position),
        .cmd              (cmd),
        .sts              (sts),
        .m_status         (m_status),
        .m_found          (m_found),
        .m_slot           (m_slot),
        .m_list_position  (m_list_position),
        .m_entity_out     (m_entity_out),
        .m_collider_out   (m_collider_out),
        .m_marked         (m_marked),
        .m_count          (m_count)
    );

endmodule
